/* hw/rtl/auto_gain_controller_macros.svh */
// Assertion helpers for the gain controller.
`ifndef AUTO_GAIN_CONTROLLER_MACROS_SVH
`define AUTO_GAIN_CONTROLLER_MACROS_SVH

// Implication checked on every edge outside reset.
`define AGC_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("agc check failed");

// Condition that must never hold outside reset.
`define AGC_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("agc forbidden condition");

`endif

/* hw/rtl/agc_pkg.sv */
`timescale 1ns / 1ps

package agc_pkg;

  localparam int MAX_REGIONS = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [9:0]  GAIN_LO      = 10'd13;
  localparam logic [9:0]  GAIN_HI      = 10'd1010;
  localparam logic [31:0] SPARSE_LIMIT = 32'd100;
  localparam logic [13:0] EMA_ALPHA    = 14'd9830;
  localparam logic [15:0] EMA_KEEP     = 16'd55706;
  localparam logic [23:0] RAW_MAX      = 24'hFFFFFF;
  // floor(m * RECIP3 / 2^17) == floor(m / 3) for m < 1024
  localparam logic [15:0] RECIP3       = 16'd43691;

  localparam logic [2:0] REG_AGC_REGION    = 3'd0;
  localparam logic [2:0] REG_GAIN_RATIO    = 3'd1;
  localparam logic [2:0] REG_AGC_PERIOD    = 3'd2;
  localparam logic [2:0] REG_DEADBAND      = 3'd3;
  localparam logic [2:0] REG_MAX_STEP      = 3'd4;
  localparam logic [2:0] REG_SETTLE_FRAMES = 3'd5;

  localparam logic [7:0] RST_AGC_REGION    = 8'd104;
  localparam logic [9:0] RST_GAIN_RATIO    = 10'd30;
  localparam logic [7:0] RST_AGC_PERIOD    = 8'd30;
  localparam logic [9:0] RST_DEADBAND      = 10'd8;
  localparam logic [9:0] RST_MAX_STEP      = 10'd80;
  localparam logic [3:0] RST_SETTLE_FRAMES = 4'd3;

  typedef struct packed {
    logic [31:0] red_sum;
    logic [31:0] green_sum;
    logic [31:0] blue_sum;
    logic [31:0] pixel_count;
    logic        last_region;
  } stats_t;

  typedef struct packed {
    logic [9:0] gain_code;
    logic       status;
  } gain_t;

  typedef struct packed {
    logic [7:0] agc_region;
    logic [9:0] bright_div;
    logic [7:0] agc_period;
    logic [9:0] deadband;
    logic [9:0] max_step;
    logic [3:0] settle_frames;
  } cfg_t;

  // One pending control step: what the metering region gave.
  typedef struct packed {
    logic        captured;
    logic [33:0] sum;
    logic [31:0] count;
  } job_t;

endpackage

/* hw/rtl/agc_front.sv */
`timescale 1ns / 1ps

module agc_front (
  input  logic             clk,
  input  logic             rst,
  input  agc_pkg::cfg_t    cfg,
  input  logic             stats_valid,
  output logic             stats_ready,
  input  agc_pkg::stats_t  stats,
  input  logic             q_full,
  output logic             q_push,
  output agc_pkg::job_t    q_job
);

  logic [7:0]  region_position;
  logic        region_captured;
  logic [33:0] captured_sum;
  logic [31:0] captured_count;
  logic [7:0]  frame_counter;

  logic        take;
  logic        hit;
  logic [33:0] rec_sum;
  logic [7:0]  frame_inc;
  logic        due;

  assign stats_ready = !q_full;
  assign take        = stats_valid && stats_ready;

  assign hit = !region_captured &&
               ({1'b0, region_position} < 9'(agc_pkg::MAX_REGIONS)) &&
               (region_position == cfg.agc_region);
  assign rec_sum = 34'(stats.red_sum) + 34'(stats.green_sum) + 34'(stats.blue_sum);

  assign frame_inc = frame_counter + 8'd1;
  assign due       = frame_inc >= cfg.agc_period;

  assign q_push         = take && stats.last_region && due;
  assign q_job.captured = region_captured || hit;
  assign q_job.sum      = hit ? rec_sum : captured_sum;
  assign q_job.count    = hit ? stats.pixel_count : captured_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_position <= '0;
      region_captured <= 1'b0;
      frame_counter   <= '0;
    end else if (take) begin
      if (stats.last_region) begin
        region_position <= '0;
        region_captured <= 1'b0;
        frame_counter   <= due ? 8'd0 : frame_inc;
      end else begin
        if (hit) begin
          region_captured <= 1'b1;
        end
        if (region_position != 8'd255) begin
          region_position <= region_position + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && hit) begin
      captured_sum   <= rec_sum;
      captured_count <= stats.pixel_count;
    end
  end

endmodule

/* hw/rtl/agc_queue.sv */
`timescale 1ns / 1ps

module agc_queue #(
  parameter int DEPTH = agc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  agc_pkg::job_t push_job,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output agc_pkg::job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  agc_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full      = fill == CW'(DEPTH);
  assign not_empty = fill != '0;
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

/* hw/rtl/agc_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module agc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [33:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [33:0] quotient
);

  logic [33:0] quo;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        run;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial    = {rem, quo[33]};
  assign diff     = trial - {1'b0, dsr};
  assign ge       = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 6'd34;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (run) begin
      quo <= {quo[32:0], ge};
      rem <= ge ? diff[31:0] : trial[31:0];
    end
  end

endmodule

/* hw/rtl/agc_back.sv */
`timescale 1ns / 1ps

module agc_back (
  input  logic          clk,
  input  logic          rst,
  input  agc_pkg::cfg_t cfg,
  input  logic          q_not_empty,
  output logic          q_pop,
  input  agc_pkg::job_t q_job,
  output logic          gain_valid,
  input  logic          gain_ready,
  output agc_pkg::gain_t gain
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV1  = 4'd1;
  localparam logic [3:0] S_DIV2  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_TGT   = 4'd6;
  localparam logic [3:0] S_GAIN  = 4'd7;
  localparam logic [3:0] S_APPLY = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]  state;
  logic [3:0]  settle_left;
  logic [39:0] filtered_gain;
  logic        filter_primed;
  logic [9:0]  cur_gain;
  logic        gain_primed;

  logic        sparse;
  logic [23:0] mean;
  logic [37:0] prod_a;
  logic [35:0] prod_lo;
  logic [35:0] prod_hi;
  logic [9:0]  target;
  logic [9:0]  step_mag;
  logic        step_neg;
  agc_pkg::gain_t result;

  logic        div_start;
  logic [33:0] div_a;
  logic [31:0] div_b;
  logic        div_done;
  logic [33:0] div_q;

  logic [34:0] mean_wide;
  logic [23:0] mean_sat;
  logic [56:0] ema_sum;
  logic [40:0] tgt_round;
  logic [24:0] tgt_int;
  logic [9:0]  tgt_clamped;
  logic [10:0] err;
  logic [9:0]  mag;
  logic [25:0] third_prod;
  logic [9:0]  third;
  logic [11:0] moved;
  logic [9:0]  applied_next;

  agc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q_pop = (state == S_IDLE) && q_not_empty;

  assign mean_wide = sparse ? {div_q, 1'b0} : {1'b0, div_q};
  assign mean_sat  = (mean_wide > 35'(agc_pkg::RAW_MAX)) ? agc_pkg::RAW_MAX : mean_wide[23:0];

  assign ema_sum = {3'b0, prod_a, 16'b0} + {1'b0, prod_hi, 20'b0} + 57'(prod_lo) + 57'd32768;

  assign tgt_round = {1'b0, filtered_gain} + 41'd32768;
  assign tgt_int   = tgt_round[40:16];
  always_comb begin
    if (tgt_int > 25'(agc_pkg::GAIN_HI)) begin
      tgt_clamped = agc_pkg::GAIN_HI;
    end else if (tgt_int < 25'(agc_pkg::GAIN_LO)) begin
      tgt_clamped = agc_pkg::GAIN_LO;
    end else begin
      tgt_clamped = tgt_int[9:0];
    end
  end

  assign err        = {1'b0, target} - {1'b0, cur_gain};
  assign mag        = err[10] ? 10'(-err) : err[9:0];
  assign third_prod = mag * agc_pkg::RECIP3;
  assign third      = {1'b0, third_prod[25:17]};

  // applied gain is in range once primed, so the sum fits 12 signed bits
  assign moved = step_neg ? {2'b0, cur_gain} - {2'b0, step_mag}
                          : {2'b0, cur_gain} + {2'b0, step_mag};
  always_comb begin
    if (moved[11] || moved < 12'(agc_pkg::GAIN_LO)) begin
      applied_next = agc_pkg::GAIN_LO;
    end else if (moved > 12'(agc_pkg::GAIN_HI)) begin
      applied_next = agc_pkg::GAIN_HI;
    end else begin
      applied_next = moved[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      settle_left   <= '0;
      filter_primed <= 1'b0;
      gain_primed   <= 1'b0;
      gain_valid    <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (gain_valid && gain_ready) begin
        gain_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_not_empty) begin
            if (settle_left != 4'd0) begin
              settle_left <= settle_left - 4'd1;
            end else if (!q_job.captured) begin
              state <= S_EMIT;
            end else if (q_job.count == 32'd0) begin
              state <= S_GAIN;
            end else begin
              div_start <= 1'b1;
              state     <= S_DIV1;
            end
          end
        end
        S_DIV1: begin
          if (div_done) begin
            div_start <= 1'b1;
            state     <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_done) begin
            if (!filter_primed) begin
              filter_primed <= 1'b1;
              state         <= S_TGT;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_SUM;
        S_SUM:   state <= S_TGT;
        S_TGT:   state <= S_GAIN;
        S_GAIN: begin
          if (!gain_primed) begin
            gain_primed <= 1'b1;
            settle_left <= cfg.settle_frames;
            state       <= S_EMIT;
          end else if (mag <= cfg.deadband) begin
            state <= S_IDLE;
          end else begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          settle_left <= cfg.settle_frames;
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (!gain_valid || gain_ready) begin
            gain_valid <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        sparse <= q_job.count < agc_pkg::SPARSE_LIMIT;
        div_a  <= q_job.sum;
        div_b  <= q_job.count;
        target <= agc_pkg::GAIN_LO;
        result <= '{gain_code: 10'd0, status: 1'b1};
      end
      S_DIV1: begin
        div_a <= div_q;
        div_b <= (cfg.bright_div == 10'd0) ? 32'd1 : 32'(cfg.bright_div);
      end
      S_DIV2: begin
        mean <= mean_sat;
        if (!filter_primed) begin
          filtered_gain <= {mean_sat, 16'b0};
        end
      end
      S_MUL1: begin
        prod_a  <= mean * agc_pkg::EMA_ALPHA;
        prod_lo <= filtered_gain[19:0] * agc_pkg::EMA_KEEP;
      end
      S_MUL2: prod_hi <= filtered_gain[39:20] * agc_pkg::EMA_KEEP;
      S_SUM:  filtered_gain <= ema_sum[55:16];
      S_TGT:  target <= tgt_clamped;
      S_GAIN: begin
        step_neg <= err[10];
        step_mag <= (third > cfg.max_step) ? cfg.max_step : third;
        if (!gain_primed) begin
          cur_gain <= target;
          result   <= '{gain_code: ~target, status: 1'b0};
        end
      end
      S_APPLY: begin
        cur_gain <= applied_next;
        result   <= '{gain_code: ~applied_next, status: 1'b0};
      end
      S_EMIT: begin
        if (!gain_valid || gain_ready) begin
          gain <= result;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/auto_gain_controller.sv */
`timescale 1ns / 1ps

// Auto gain controller.
// Input channel (stats_valid/stats_ready/stats): one region record word per
// cycle, the record with last_region set closes the frame. Records are taken
// back to back; ready drops only while the step queue (QUEUE_DEPTH entries)
// holds that many frames still waiting for their control step.
// Output channel (gain_valid/gain_ready/gain): at most one word per frame
// that runs a control step, carrying the new gain code or the missing-region
// flag. While settling a step only counts down; a missing region goes straight
// to the output, a starved region skips to the gain step, and a computed mean
// takes two passes of the shared serial divider (sum/count, then /ratio)
// plus the filter multiplies.
// The result sits in an output register; a stalled receiver holds the word
// while the front keeps taking records until the queue fills.
// Configuration: cfg_we with cfg_index/cfg_data writes one register per
// cycle, no wait; write only while no step is pending.
// Reset (rst, synchronous) restores register defaults, empties the queue
// and clears the filter and gain history.
`include "auto_gain_controller_macros.svh"

module auto_gain_controller #(
  parameter int QUEUE_DEPTH = agc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [9:0]      cfg_data,
  input  logic            stats_valid,
  output logic            stats_ready,
  input  agc_pkg::stats_t stats,
  output logic            gain_valid,
  input  logic            gain_ready,
  output agc_pkg::gain_t  gain
);

  agc_pkg::cfg_t cfg;
  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_not_empty;
  agc_pkg::job_t push_job;
  agc_pkg::job_t pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.agc_region    <= agc_pkg::RST_AGC_REGION;
      cfg.bright_div    <= agc_pkg::RST_GAIN_RATIO;
      cfg.agc_period    <= agc_pkg::RST_AGC_PERIOD;
      cfg.deadband      <= agc_pkg::RST_DEADBAND;
      cfg.max_step      <= agc_pkg::RST_MAX_STEP;
      cfg.settle_frames <= agc_pkg::RST_SETTLE_FRAMES;
    end else if (cfg_we) begin
      case (cfg_index)
        agc_pkg::REG_AGC_REGION:    cfg.agc_region    <= cfg_data[7:0];
        agc_pkg::REG_GAIN_RATIO:    cfg.bright_div    <= cfg_data;
        agc_pkg::REG_AGC_PERIOD:    cfg.agc_period    <= cfg_data[7:0];
        agc_pkg::REG_DEADBAND:      cfg.deadband      <= cfg_data;
        agc_pkg::REG_MAX_STEP:      cfg.max_step      <= cfg_data;
        agc_pkg::REG_SETTLE_FRAMES: cfg.settle_frames <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  agc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .stats_valid (stats_valid),
    .stats_ready (stats_ready),
    .stats       (stats),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  agc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_job   (pop_job)
  );

  agc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .q_job       (pop_job),
    .gain_valid  (gain_valid),
    .gain_ready  (gain_ready),
    .gain        (gain)
  );

  `AGC_NEVER(a_queue_overflow, q_push && q_full)
  `AGC_CHECK(a_missing_code, gain_valid && gain.status |-> gain.gain_code == 10'd0)
  `AGC_CHECK(a_code_range, gain_valid && !gain.status |-> gain.gain_code >= 10'd13 && gain.gain_code <= 10'd1010)

endmodule

/* bench/auto_gain_controller_tb.sv */
`timescale 1ns / 1ps

module auto_gain_controller_tb;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;

  logic clk, rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [9:0] cfg_data;
  logic stats_valid, stats_ready;
  agc_pkg::stats_t stats;
  logic gain_valid, gain_ready;
  agc_pkg::gain_t gain;

  auto_gain_controller u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .stats_valid(stats_valid), .stats_ready(stats_ready), .stats(stats),
    .gain_valid(gain_valid), .gain_ready(gain_ready), .gain(gain)
  );

  // predictor copy of the registers and state
  logic [7:0] m_region, m_period;
  logic [9:0] m_ratio, m_deadband, m_max_step;
  logic [3:0] m_settle_frames;
  int unsigned m_pos;
  bit m_captured;
  logic [33:0] m_sum;
  logic [31:0] m_count;
  logic [7:0] m_frames;
  logic [3:0] m_settle;
  logic [39:0] m_filt;
  bit m_filt_primed;
  int m_applied;
  bit m_gain_primed;

  agc_pkg::stats_t pending_words[$];
  agc_pkg::gain_t expected_gains[$];

  int idle_mode;
  int errors, words_in, gains_out, misses_seen, stall_cnt;
  int hold_req, hold_seen, hold_left;
  bit in_fire;
  // generator-side view of the settings
  int gen_region, gen_ratio;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int clamp_gain(int g);
    if (g < int'(agc_pkg::GAIN_LO)) return int'(agc_pkg::GAIN_LO);
    if (g > int'(agc_pkg::GAIN_HI)) return int'(agc_pkg::GAIN_HI);
    return g;
  endfunction

  function automatic int calc_target();
    logic [63:0] mean, filt_next, t;
    if (m_count == 0) return int'(agc_pkg::GAIN_LO);
    mean = 64'(m_sum) / 64'(m_count);
    mean = mean / 64'((m_ratio == 0) ? 10'd1 : m_ratio);
    if (m_count < agc_pkg::SPARSE_LIMIT) mean = mean * 2;
    if (mean > 64'(agc_pkg::RAW_MAX)) mean = 64'(agc_pkg::RAW_MAX);
    if (!m_filt_primed) begin
      m_filt = 40'(mean << 16);
      m_filt_primed = 1;
    end else begin
      filt_next = (64'(agc_pkg::EMA_ALPHA) * (mean << 16) +
                   64'(agc_pkg::EMA_KEEP) * 64'(m_filt) + 64'd32768) >> 16;
      m_filt = filt_next[39:0];
    end
    t = (64'(m_filt) + 64'd32768) >> 16;
    if (t > 64'(agc_pkg::GAIN_HI)) t = 64'(agc_pkg::GAIN_HI);
    return clamp_gain(int'(t));
  endfunction

  task automatic control_step();
    int tgt, err, mag, step;
    agc_pkg::gain_t g;
    if (m_settle > 0) begin
      m_settle--;
      return;
    end
    if (!m_captured) begin
      g.gain_code = '0;
      g.status = 1'b1;
      expected_gains.push_back(g);
      return;
    end
    tgt = calc_target();
    if (!m_gain_primed) begin
      m_applied = tgt;
      m_gain_primed = 1;
    end else begin
      err = tgt - m_applied;
      mag = (err < 0) ? -err : err;
      if (mag <= int'(m_deadband)) return;
      step = err / 3;
      if (step > int'(m_max_step)) step = int'(m_max_step);
      else if (step < -int'(m_max_step)) step = -int'(m_max_step);
      m_applied = clamp_gain(m_applied + step);
    end
    m_settle = m_settle_frames;
    g.gain_code = 10'(1023 - m_applied);
    g.status = 1'b0;
    expected_gains.push_back(g);
  endtask

  task automatic predict_record(agc_pkg::stats_t s);
    if (!m_captured && m_pos < agc_pkg::MAX_REGIONS && m_pos == m_region) begin
      m_sum = 34'(s.red_sum) + 34'(s.green_sum) + 34'(s.blue_sum);
      m_count = s.pixel_count;
      m_captured = 1;
    end
    if (m_pos < 255) m_pos++;
    if (s.last_region) begin
      m_frames = m_frames + 8'd1;
      if (m_frames >= m_period) begin
        m_frames = '0;
        control_step();
      end
      m_pos = 0;
      m_captured = 0;
    end
  endtask

  // input side: predict on accept, apply register writes to the predictor
  always @(posedge clk) begin
    if (rst) begin
      m_region = agc_pkg::RST_AGC_REGION; m_ratio = agc_pkg::RST_GAIN_RATIO;
      m_period = agc_pkg::RST_AGC_PERIOD;
      m_deadband = agc_pkg::RST_DEADBAND; m_max_step = agc_pkg::RST_MAX_STEP;
      m_settle_frames = agc_pkg::RST_SETTLE_FRAMES;
      m_pos = 0; m_captured = 0; m_sum = '0; m_count = '0; m_frames = '0; m_settle = '0;
      m_filt = '0; m_filt_primed = 0; m_applied = 0; m_gain_primed = 0;
      in_fire <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          agc_pkg::REG_AGC_REGION:    m_region = cfg_data[7:0];
          agc_pkg::REG_GAIN_RATIO:    m_ratio = cfg_data;
          agc_pkg::REG_AGC_PERIOD:    m_period = cfg_data[7:0];
          agc_pkg::REG_DEADBAND:      m_deadband = cfg_data;
          agc_pkg::REG_MAX_STEP:      m_max_step = cfg_data;
          agc_pkg::REG_SETTLE_FRAMES: m_settle_frames = cfg_data[3:0];
          default: ;
        endcase
      end
      in_fire <= stats_valid && stats_ready;
      if (stats_valid && stats_ready) begin
        predict_record(stats);
        words_in++;
      end
    end
  end

  // output monitor and watchdog
  always @(posedge clk) begin
    agc_pkg::gain_t want;
    if (!rst) begin
      if (gain_valid && gain_ready) begin
        gains_out++;
        if (gain.status) misses_seen++;
        if (expected_gains.size() == 0) begin
          $display("%0t: unexpected gain word, expected none, actual code=%0d status=%0d",
                   $time, gain.gain_code, gain.status);
          errors++;
        end else begin
          want = expected_gains.pop_front();
          if (gain.gain_code !== want.gain_code) begin
            $display("%0t: gain_code mismatch, expected %0d actual %0d", $time,
                     want.gain_code, gain.gain_code);
            errors++;
          end
          if (gain.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time,
                     want.status, gain.status);
            errors++;
          end
        end
      end
      if ((stats_valid && stats_ready) || (gain_valid && gain_ready) || cfg_we) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst) begin
      stats_valid <= 1'b0;
    end else if (!stats_valid || in_fire) begin
      if (pending_words.size() > 0 &&
          !(idle_mode == 0 && $urandom_range(99) < 27) &&
          !(idle_mode == 1 && $urandom_range(99) < 64)) begin
        stats <= pending_words.pop_front();
        stats_valid <= 1'b1;
      end else begin
        stats_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      gain_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      gain_ready <= 1'b0;
    end else if (idle_mode == 0) begin
      gain_ready <= ($urandom_range(99) >= 64);
    end else if (idle_mode == 1) begin
      gain_ready <= ($urandom_range(99) >= 27);
    end else begin
      gain_ready <= 1'b1;
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() > 0 || stats_valid || expected_gains.size() > 0);
    // steps may still be running or queued that yield no word
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 10'(val);
  endtask

  task automatic configure(int region, int ratio, int period, int dband, int mstep, int settle);
    write_reg(agc_pkg::REG_AGC_REGION, region);
    write_reg(agc_pkg::REG_GAIN_RATIO, ratio);
    write_reg(agc_pkg::REG_AGC_PERIOD, period);
    write_reg(agc_pkg::REG_DEADBAND, dband);
    write_reg(agc_pkg::REG_MAX_STEP, mstep);
    write_reg(agc_pkg::REG_SETTLE_FRAMES, settle);
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_region = region;
    gen_ratio = (ratio == 0) ? 1 : ratio;
  endtask

  function automatic agc_pkg::stats_t make_record(bit last);
    agc_pkg::stats_t s;
    longint unsigned cnt, ch;
    int kind;
    kind = $urandom_range(0, 11);
    s.last_region = last;
    case (kind)
      0: begin
        s.red_sum = '0; s.green_sum = '0; s.blue_sum = '0; s.pixel_count = '0;
      end
      1: begin
        s.red_sum = '1; s.green_sum = '1; s.blue_sum = '1; s.pixel_count = '1;
      end
      2: begin
        s.red_sum = $urandom; s.green_sum = $urandom; s.blue_sum = $urandom;
        s.pixel_count = $urandom;
      end
      3: begin
        s.red_sum = $urandom; s.green_sum = $urandom; s.blue_sum = $urandom;
        s.pixel_count = $urandom_range(0, 120);
      end
      default: begin
        // sums chosen so the mean lands near a chosen gain
        cnt = $urandom_range(1, 1500);
        ch = cnt * longint'($urandom_range(0, 1200)) * longint'(gen_ratio) / 3;
        s.red_sum = 32'(ch + $urandom_range(0, 3));
        s.green_sum = 32'(ch);
        s.blue_sum = 32'(ch);
        s.pixel_count = 32'(cnt);
      end
    endcase
    return s;
  endfunction

  task automatic add_frame(int nrec);
    for (int i = 0; i < nrec; i++) pending_words.push_back(make_record(i == nrec - 1));
  endtask

  // frames mostly cover the metering region, sometimes stop short of it
  task automatic add_frames(int nwords);
    int n, len;
    n = 0;
    while (n < nwords) begin
      if ($urandom_range(0, 9) == 0) len = (gen_region == 0) ? 1 : $urandom_range(1, gen_region);
      else len = gen_region + 1 + $urandom_range(0, 3);
      add_frame(len);
      n += len;
    end
  endtask

  initial begin
    agc_pkg::stats_t s;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    stats_valid = 1'b0; stats = '0; gain_ready = 1'b0;
    idle_mode = 2; errors = 0; words_in = 0; gains_out = 0; misses_seen = 0;
    stall_cnt = 0; hold_req = 0; hold_seen = 0; hold_left = 0;
    gen_region = agc_pkg::RST_AGC_REGION; gen_ratio = agc_pkg::RST_GAIN_RATIO;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, starved and sparse regions, missing region
    idle_mode = 0;
    configure(0, 1, 1, 0, 1023, 0);
    s = '{red_sum: '1, green_sum: '1, blue_sum: '1, pixel_count: 32'd1, last_region: 1'b1};
    pending_words.push_back(s);
    s = '{red_sum: 0, green_sum: 0, blue_sum: 0, pixel_count: 0, last_region: 1'b1};
    pending_words.push_back(s);
    s = '{red_sum: 32'd1000, green_sum: 32'd1000, blue_sum: 32'd1000,
          pixel_count: 32'd99, last_region: 1'b1};
    pending_words.push_back(s);
    s.pixel_count = 32'd100;
    pending_words.push_back(s);
    s = '{red_sum: 32'd50, green_sum: 32'd60, blue_sum: 32'd70,
          pixel_count: 32'd1, last_region: 1'b1};
    pending_words.push_back(s);
    wait_idle();
    configure(1, 0, 1, 1023, 0, 15);
    add_frame(1);
    add_frame(3);
    add_frame(2);
    wait_idle();
    // zero step still reports; region at the end of a very long frame
    configure(255, 1023, 1, 0, 0, 0);
    add_frame(2);
    add_frame(260);
    wait_idle();

    // random phases
    configure(2, 30, 1, 4, 80, 0);
    add_frames(70);
    wait_idle();
    configure(0, 7, 2, 0, 1, 1);
    add_frames(50);
    // sender pauses until everything is back
    wait_idle();
    add_frames(20);
    wait_idle();
    idle_mode = 1;
    configure(3, 100, 1, 20, 300, 2);
    add_frames(70);
    wait_idle();
    configure(1, 512, 255, 8, 1023, 0);
    add_frames(40);
    wait_idle();
    configure(0, 1, 3, 1023, 5, 15);
    add_frames(40);
    wait_idle();
    idle_mode = 2;
    // receiver holds off while records keep coming
    configure(0, 30, 1, 0, 50, 0);
    add_frames(80);
    hold_req = hold_req + 1;
    wait_idle();
    configure(1, 60, 1, 2, 200, 0);
    add_frames(70);
    wait_idle();

    $display("Covered %0d region words and %0d gain words (%0d missing-region flags)",
             words_in, gains_out, misses_seen);
    $display("across register sweeps incl. zero/extreme ratio, period, step and settle.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
